// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SRTF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition never holds
`define SRTF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/srtf_pkg.sv =====
// shared widths and controller/datapath interface types
`default_nettype none

package srtf_pkg;

	localparam int ARR_W  = 16;
	localparam int BUR_W  = 16;
	localparam int NUM_W  = 7;
	localparam int CNT_W  = 7;
	localparam int TIME_W = 23;
	localparam int TOT_W  = 29;

	// commands from controller to datapath
	typedef struct packed {
		logic load;     // input item accepted
		logic restart;  // clear scan state and index
		logic scan;     // examine one stored entry
		logic apply;    // advance time by the chosen run, or to the next arrival when none is ready
		logic emit;     // load the output register
		logic clear;    // return counters to zero after a run
	} srtf_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic all_done;
		logic idx_last;
		logic empty;
		logic out_free;
	} srtf_status_t;

endpackage

`default_nettype wire

// ===== rtl/srtf_ctrl.sv =====
// controller state machine: load, scan, apply and emit phases
`default_nettype none

module srtf_ctrl
	import srtf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         last_process,
	output logic         in_ready,
	input  srtf_status_t st,
	output srtf_cmd_t    cmd
);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_APPLY = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && last_process) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.restart = 1'b1;
				state_d     = st.all_done ? ST_EMIT : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.idx_last) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.empty || st.idx_last) begin
						cmd.clear = 1'b1;
						state_d   = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/srtf_datapath.sv =====
// process table, scan unit, time advance and output register
`default_nettype none

module srtf_datapath
	import srtf_pkg::*;
#(
	parameter int MAX_PROCS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  srtf_cmd_t           cmd,
	output srtf_status_t        st,
	input  logic [ARR_W-1:0]    arrival_time,
	input  logic [BUR_W-1:0]    burst_time,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [NUM_W-1:0]    process_number,
	output logic [ARR_W-1:0]    arrival_echo,
	output logic [BUR_W-1:0]    burst_echo,
	output logic [TIME_W-1:0]   finish_time,
	output logic [TOT_W-1:0]    total_waiting,
	output logic [TOT_W-1:0]    total_turnaround,
	output logic                final_result,
	output logic                overflow_seen
);

	localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

	// table, kept sorted by arrival
	logic [ARR_W-1:0]  arr_q [MAX_PROCS];
	logic [BUR_W-1:0]  bur_q [MAX_PROCS];
	logic [BUR_W-1:0]  rem_q [MAX_PROCS];
	logic [NUM_W-1:0]  num_q [MAX_PROCS];
	logic [TIME_W-1:0] fin_q [MAX_PROCS];

	logic [CNT_W-1:0]  loaded_q;
	logic [CNT_W-1:0]  done_q;
	logic [TIME_W-1:0] time_q;
	logic              ovf_q;
	logic [IDX_W-1:0]  idx_q;

	// scan results
	logic              found_q;
	logic [IDX_W-1:0]  best_q;
	logic [BUR_W-1:0]  best_rem_q;
	logic              has_next_q;
	logic [ARR_W-1:0]  next_arr_q;

	logic [TOT_W-1:0]  tt_q;
	logic [TOT_W-1:0]  tw_q;

	logic              out_valid_q;

	logic              ins;
	logic              full;
	logic [MAX_PROCS-1:0] le;

	logic [ARR_W-1:0]  rd_arr;
	logic [BUR_W-1:0]  rd_bur;
	logic [BUR_W-1:0]  rd_rem;
	logic [NUM_W-1:0]  rd_num;
	logic [TIME_W-1:0] rd_fin;

	logic              arrived;
	logic [TIME_W-1:0] gap;
	logic [BUR_W-1:0]  run;
	logic [BUR_W-1:0]  new_rem;
	logic [TIME_W-1:0] time_new;
	logic              apply_wr;

	logic [TIME_W-1:0] turn;
	logic [TOT_W-1:0]  tt_new;
	logic [TOT_W-1:0]  tw_new;

	assign full = (loaded_q >= CNT_W'(MAX_PROCS));
	assign ins  = cmd.load && (burst_time != '0) && !full;

	// entries at or below the new arrival form a prefix of the valid part
	always_comb begin
		for (int i = 0; i < MAX_PROCS; i++) begin
			le[i] = (CNT_W'(i) < loaded_q) && (arr_q[i] <= arrival_time);
		end
	end

	assign rd_arr = arr_q[idx_q];
	assign rd_bur = bur_q[idx_q];
	assign rd_rem = rem_q[idx_q];
	assign rd_num = num_q[idx_q];
	assign rd_fin = fin_q[idx_q];

	// time advance
	assign arrived  = ({{(TIME_W-ARR_W){1'b0}}, rd_arr} <= time_q);
	assign gap      = {{(TIME_W-ARR_W){1'b0}}, next_arr_q} - time_q;
	assign run      = (has_next_q && (gap < {{(TIME_W-BUR_W){1'b0}}, best_rem_q}))
			? gap[BUR_W-1:0] : best_rem_q;
	assign new_rem  = best_rem_q - run;
	assign time_new = time_q + {{(TIME_W-BUR_W){1'b0}}, run};
	assign apply_wr = cmd.apply && found_q;

	// totals over the emitted entries
	assign turn   = rd_fin - {{(TIME_W-ARR_W){1'b0}}, rd_arr};
	assign tt_new = tt_q + {{(TOT_W-TIME_W){1'b0}}, turn};
	assign tw_new = tw_q + {{(TOT_W-TIME_W){1'b0}},
			turn - {{(TIME_W-BUR_W){1'b0}}, rd_bur}};

	for (genvar g = 0; g < MAX_PROCS; g++) begin : g_ent
		logic             prev_le;
		logic [ARR_W-1:0] sh_arr;
		logic [BUR_W-1:0] sh_bur;
		logic [NUM_W-1:0] sh_num;

		if (g == 0) begin : g_first
			assign prev_le = 1'b1;
			assign sh_arr  = arrival_time;
			assign sh_bur  = burst_time;
			assign sh_num  = loaded_q + 1'b1;
		end else begin : g_rest
			assign prev_le = le[g-1];
			assign sh_arr  = arr_q[g-1];
			assign sh_bur  = bur_q[g-1];
			assign sh_num  = num_q[g-1];
		end

		always_ff @(posedge clk) begin
			if (ins) begin
				if (!le[g]) begin
					if (prev_le) begin
						arr_q[g] <= arrival_time;
						bur_q[g] <= burst_time;
						rem_q[g] <= burst_time;
						num_q[g] <= loaded_q + 1'b1;
					end else begin
						arr_q[g] <= sh_arr;
						bur_q[g] <= sh_bur;
						rem_q[g] <= sh_bur;
						num_q[g] <= sh_num;
					end
				end
			end else if (apply_wr && (best_q == IDX_W'(g))) begin
				rem_q[g] <= new_rem;
				if (new_rem == '0) begin
					fin_q[g] <= time_new;
				end
			end
		end
	end

	// counters and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			done_q   <= '0;
			time_q   <= '0;
			ovf_q    <= 1'b0;
			idx_q    <= '0;
			tt_q     <= '0;
			tw_q     <= '0;
		end else begin
			if (cmd.load && (burst_time != '0) && full) begin
				ovf_q <= 1'b1;
			end
			if (ins) begin
				loaded_q <= loaded_q + 1'b1;
			end
			if (cmd.restart) begin
				idx_q <= '0;
			end else if (cmd.scan || cmd.emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.apply) begin
				if (!found_q) begin
					time_q <= {{(TIME_W-ARR_W){1'b0}}, next_arr_q};
				end else begin
					time_q <= time_new;
					if (new_rem == '0) begin
						done_q <= done_q + 1'b1;
					end
				end
			end
			if (cmd.emit && !cmd.clear) begin
				tt_q <= tt_new;
				tw_q <= tw_new;
			end
			if (cmd.clear) begin
				loaded_q <= '0;
				done_q   <= '0;
				time_q   <= '0;
				ovf_q    <= 1'b0;
				tt_q     <= '0;
				tw_q     <= '0;
			end
		end
	end

	// scan over the table, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			has_next_q <= 1'b0;
		end else if (cmd.restart) begin
			found_q    <= 1'b0;
			has_next_q <= 1'b0;
		end else if (cmd.scan) begin
			if (arrived) begin
				if ((rd_rem != '0) && (!found_q || (rd_rem < best_rem_q))) begin
					found_q <= 1'b1;
				end
			end else begin
				has_next_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			if (arrived) begin
				if ((rd_rem != '0) && (!found_q || (rd_rem < best_rem_q))) begin
					best_q     <= idx_q;
					best_rem_q <= rd_rem;
				end
			end else if (!has_next_q || (rd_arr < next_arr_q)) begin
				next_arr_q <= rd_arr;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (st.empty) begin
				process_number   <= '0;
				arrival_echo     <= '0;
				burst_echo       <= '0;
				finish_time      <= '0;
				total_waiting    <= '0;
				total_turnaround <= '0;
				final_result     <= 1'b1;
				overflow_seen    <= ovf_q;
			end else begin
				process_number   <= rd_num;
				arrival_echo     <= rd_arr;
				burst_echo       <= rd_bur;
				finish_time      <= rd_fin;
				total_waiting    <= st.idx_last ? tw_new : '0;
				total_turnaround <= st.idx_last ? tt_new : '0;
				final_result     <= st.idx_last;
				overflow_seen    <= st.idx_last && ovf_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign st.all_done = (done_q == loaded_q);
	assign st.idx_last = ((CNT_W'(idx_q) + 1'b1) == loaded_q);
	assign st.empty    = (loaded_q == '0);
	assign st.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

// ===== rtl/srtf_schedule_simulator.sv =====
// shortest-remaining-time-first scheduler: top level
//
// input channel (in_valid/in_ready): one process per item, arrival_time and
// burst_time; last_process marks the final item and starts the run. items
// with zero burst are not stored; items beyond MAX_PROCS are dropped and
// reported through overflow_seen on the last result.
// in_ready is high whenever the block is loading, even while an earlier
// result still sits in the output register, so items are taken back to back.
// the run works event by event: each event is a check state, a scan over
// every stored entry and an apply state, and a run of n processes takes at
// most about 2n events.
// output channel (out_valid/out_ready): one result per stored process in
// arrival order, one per cycle while the receiver takes them; the last one
// carries final_result and the totals. an empty set gives a single result.
// a stalled receiver holds the result in the output register and halts the
// emit phase; nothing is lost. reset (arst_n low) empties the table and
// drops any pending result; the block comes up ready to load.
`default_nettype none
`include "assert_macros.svh"

module srtf_schedule_simulator
	import srtf_pkg::*;
#(
	parameter int MAX_PROCS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ARR_W-1:0]  arrival_time,
	input  logic [BUR_W-1:0]  burst_time,
	input  logic              last_process,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NUM_W-1:0]  process_number,
	output logic [ARR_W-1:0]  arrival_echo,
	output logic [BUR_W-1:0]  burst_echo,
	output logic [TIME_W-1:0] finish_time,
	output logic [TOT_W-1:0]  total_waiting,
	output logic [TOT_W-1:0]  total_turnaround,
	output logic              final_result,
	output logic              overflow_seen
);

	srtf_cmd_t    cmd;
	srtf_status_t st;

	// sequencing of load, scan/apply loop and emit
	srtf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.last_process (last_process),
		.in_ready     (in_ready),
		.st           (st),
		.cmd          (cmd)
	);

	// table, scheduling arithmetic and output register
	srtf_datapath #(
		.MAX_PROCS (MAX_PROCS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.arrival_time     (arrival_time),
		.burst_time       (burst_time),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.process_number   (process_number),
		.arrival_echo     (arrival_echo),
		.burst_echo       (burst_echo),
		.finish_time      (finish_time),
		.total_waiting    (total_waiting),
		.total_turnaround (total_turnaround),
		.final_result     (final_result),
		.overflow_seen    (overflow_seen)
	);

	// a process cannot finish before its arrival plus its burst
	`SRTF_ASSERT_IMPL(a_finish_bound, clk, arst_n, out_valid && (process_number != '0), finish_time >= ({{(TIME_W-ARR_W){1'b0}}, arrival_echo} + {{(TIME_W-BUR_W){1'b0}}, burst_echo}), "finish time before arrival plus burst")
	// totals and overflow appear only on the final result
	`SRTF_ASSERT_IMPL(a_totals_final, clk, arst_n, out_valid && !final_result, (total_waiting == '0) && (total_turnaround == '0) && !overflow_seen, "totals on a non-final result")
	// waiting is turnaround less burst, never larger
	`SRTF_ASSERT_IMPL(a_wait_le_turn, clk, arst_n, out_valid && final_result, total_waiting <= total_turnaround, "waiting total exceeds turnaround total")
	// emitting and loading never overlap
	`SRTF_ASSERT_NEVER(a_emit_load, clk, arst_n, cmd.emit && cmd.load, "emit during load")

endmodule

`default_nettype wire

// ===== dv/tb_srtf_schedule_simulator.sv =====
// testbench for the srtf scheduler: random process sets, stalls on both sides
`timescale 1ns / 100ps

module tb_srtf_schedule_simulator;
	import srtf_pkg::*;

	localparam int CAPACITY = 16;
	localparam int ITEM_TARGET = 470;
	// a full table runs up to about 2n events, each a check, a table scan and an apply, plus a receiver stall
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 100;
	localparam int SHOWN_MISMATCHES = 10;

	// one process as the sender sees it, with the idle cycles in front of it
	typedef struct {
		bit [ARR_W-1:0] arrival;
		bit [BUR_W-1:0] burst;
		bit last;
		int unsigned gap;
	} proc_item_t;

	// one scheduler report, four-state so that unknown outputs fail the compare
	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic [ARR_W-1:0] arrival;
		logic [BUR_W-1:0] burst;
		logic [TIME_W-1:0] finish;
		logic [TOT_W-1:0] waiting;
		logic [TOT_W-1:0] turnaround;
		logic final_flag;
		logic ovf;
	} sched_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ARR_W-1:0] arrival_time = '0;
	logic [BUR_W-1:0] burst_time = '0;
	logic last_process = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [NUM_W-1:0] process_number;
	logic [ARR_W-1:0] arrival_echo;
	logic [BUR_W-1:0] burst_echo;
	logic [TIME_W-1:0] finish_time;
	logic [TOT_W-1:0] total_waiting;
	logic [TOT_W-1:0] total_turnaround;
	logic final_result;
	logic overflow_seen;

	srtf_schedule_simulator #(
		.MAX_PROCS(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.arrival_time(arrival_time),
		.burst_time(burst_time),
		.last_process(last_process),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.process_number(process_number),
		.arrival_echo(arrival_echo),
		.burst_echo(burst_echo),
		.finish_time(finish_time),
		.total_waiting(total_waiting),
		.total_turnaround(total_turnaround),
		.final_result(final_result),
		.overflow_seen(overflow_seen)
	);

	always #1 clk = ~clk;

	proc_item_t procs_to_send[$];
	sched_report_t reports_due[$];
	int unsigned procs_queued = 0;
	int unsigned mismatches = 0;
	bit send_calm = 1'b0;
	bit take_calm = 1'b0;

	// predictor copy of the process table, kept sorted by arrival
	bit [ARR_W-1:0] held_arr [CAPACITY];
	bit [BUR_W-1:0] held_bur [CAPACITY];
	int unsigned held_left [CAPACITY];
	bit [NUM_W-1:0] held_num [CAPACITY];
	bit [TIME_W-1:0] held_fin [CAPACITY];
	int unsigned held_n = 0;
	bit dropped = 1'b0;

	// wait before an item or result: a random draw, or none during calm stretches
	function automatic int unsigned draw_gap(input bit calm);
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic bit [ARR_W-1:0] pick_arrival(input int unsigned span);
		case (span)
			0: return ARR_W'($urandom_range(0, 3));
			1: return ARR_W'($urandom_range(0, 40));
			2: return ARR_W'($urandom_range(0, 1000));
			default: return ARR_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic bit [BUR_W-1:0] pick_burst(input int unsigned kind);
		case (kind)
			0: return BUR_W'($urandom_range(1, 4));
			1: return BUR_W'($urandom_range(1, 50));
			default: return BUR_W'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic void queue_proc(input bit [ARR_W-1:0] a, input bit [BUR_W-1:0] b,
			input bit last);
		proc_item_t it;
		if ($urandom_range(0, 24) == 0)
			send_calm = ~send_calm;
		it.arrival = a;
		it.burst = b;
		it.last = last;
		it.gap = draw_gap(send_calm);
		procs_to_send.push_back(it);
		// zero-burst items are ignored by the block and do not count
		if (b != 0)
			procs_queued++;
	endfunction

	// stable insert by arrival, or drop when the table is full
	function automatic void store_process(input bit [ARR_W-1:0] a, input bit [BUR_W-1:0] b);
		int unsigned pos;
		int unsigned i;
		if (held_n >= CAPACITY) begin
			dropped = 1'b1;
			return;
		end
		pos = 0;
		while (pos < held_n && held_arr[pos] <= a)
			pos++;
		for (i = held_n; i > pos; i--) begin
			held_arr[i] = held_arr[i-1];
			held_bur[i] = held_bur[i-1];
			held_left[i] = held_left[i-1];
			held_num[i] = held_num[i-1];
			held_fin[i] = held_fin[i-1];
		end
		held_arr[pos] = a;
		held_bur[pos] = b;
		held_left[pos] = 32'(b);
		held_num[pos] = NUM_W'(held_n + 1);
		held_fin[pos] = '0;
		held_n++;
	endfunction

	// preemptive srtf over the held set, jumping from event to event,
	// then queue one report per process in arrival order, or a single one for an empty set
	function automatic void schedule_set();
		int unsigned now;
		int unsigned finished;
		int unsigned best;
		int unsigned best_left;
		int unsigned next_arr;
		int unsigned run;
		int unsigned i;
		int unsigned turn;
		int unsigned tw;
		int unsigned tt;
		bit found;
		bit has_next;
		sched_report_t r;
		now = 0;
		finished = 0;
		while (finished < held_n) begin
			found = 1'b0;
			has_next = 1'b0;
			best = 0;
			best_left = 0;
			next_arr = 0;
			for (i = 0; i < held_n; i++) begin
				if (held_arr[i] <= now) begin
					// strict less-than keeps the lowest position on equal remaining time
					if (held_left[i] > 0 && (!found || held_left[i] < best_left)) begin
						found = 1'b1;
						best = i;
						best_left = held_left[i];
					end
				end else if (!has_next || held_arr[i] < next_arr) begin
					has_next = 1'b1;
					next_arr = held_arr[i];
				end
			end
			if (!found) begin
				// cpu idles until the next arrival
				now = next_arr;
			end else begin
				run = best_left;
				if (has_next && next_arr - now < run)
					run = next_arr - now;
				held_left[best] -= run;
				now += run;
				if (held_left[best] == 0) begin
					held_fin[best] = now[TIME_W-1:0];
					finished++;
				end
			end
		end
		if (held_n == 0) begin
			// empty set: a single zeroed report that closes the run
			r = '0;
			r.final_flag = 1'b1;
			r.ovf = dropped;
			reports_due.push_back(r);
		end else begin
			tw = 0;
			tt = 0;
			for (i = 0; i < held_n; i++) begin
				turn = int'(held_fin[i]) - int'(held_arr[i]);
				tt += turn;
				tw += turn - held_bur[i];
				r = '0;
				r.number = held_num[i];
				r.arrival = held_arr[i];
				r.burst = held_bur[i];
				r.finish = held_fin[i];
				if (i == held_n - 1) begin
					r.waiting = tw[TOT_W-1:0];
					r.turnaround = tt[TOT_W-1:0];
					r.final_flag = 1'b1;
					r.ovf = dropped;
				end
				reports_due.push_back(r);
			end
		end
		held_n = 0;
		dropped = 1'b0;
	endfunction

	// handshake results of the last rising edge, read by the falling-edge drivers
	logic in_took = 1'b0;
	logic out_took = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;

	// sender: holds an item until taken, then idles the gap drawn for the next one
	always @(negedge clk) begin
		proc_item_t it;
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (procs_to_send.size() > 0) begin
					it = procs_to_send.pop_front();
					arrival_time <= it.arrival;
					burst_time <= it.burst;
					last_process <= it.last;
					in_valid <= 1'b1;
					gap_left <= procs_to_send.size() > 0 ? procs_to_send[0].gap : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: after each result, ready drops for a drawn number of cycles
	always @(negedge clk) begin
		int unsigned w;
		if (arst_n) begin
			if (out_took) begin
				if ($urandom_range(0, 24) == 0)
					take_calm = ~take_calm;
				w = draw_gap(take_calm);
				stall_left <= w;
				out_ready <= (w == 0);
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= (stall_left == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// result check first, then prediction for the item taken at this edge
	always @(posedge clk) begin
		sched_report_t got;
		sched_report_t want;
		if (arst_n) begin
			in_took <= in_valid && in_ready;
			out_took <= out_valid && out_ready;
			if (out_valid && out_ready) begin
				got.number = process_number;
				got.arrival = arrival_echo;
				got.burst = burst_echo;
				got.finish = finish_time;
				got.waiting = total_waiting;
				got.turnaround = total_turnaround;
				got.final_flag = final_result;
				got.ovf = overflow_seen;
				if (reports_due.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOWN_MISMATCHES)
						$display("unexpected result: num=%0d arr=%0d bur=%0d fin=%0d final=%0b",
							got.number, got.arrival, got.burst, got.finish, got.final_flag);
				end else begin
					want = reports_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= SHOWN_MISMATCHES) begin
							$display("mismatch exp: num=%0d arr=%0d bur=%0d fin=%0d wt=%0d ta=%0d fl=%0b ov=%0b",
								want.number, want.arrival, want.burst, want.finish,
								want.waiting, want.turnaround, want.final_flag, want.ovf);
							$display("         got: num=%0d arr=%0d bur=%0d fin=%0d wt=%0d ta=%0d fl=%0b ov=%0b",
								got.number, got.arrival, got.burst, got.finish,
								got.waiting, got.turnaround, got.final_flag, got.ovf);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				if (burst_time != 0)
					store_process(arrival_time, burst_time);
				if (last_process)
					schedule_set();
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	int unsigned quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned n;
		int unsigned size_kind;
		int unsigned span;
		int unsigned bur_kind;
		bit [BUR_W-1:0] b;

		// empty set: only a zero-burst closing item
		queue_proc(16'd1234, 16'd0, 1'b1);
		// single process at the field extremes
		queue_proc(16'hFFFF, 16'hFFFF, 1'b1);
		// equal arrivals keep load order, equal remaining times go to the lower slot,
		// zero-burst noise in the middle of a set
		queue_proc(16'd5, 16'd3, 1'b0);
		queue_proc(16'd0, 16'd4, 1'b0);
		queue_proc(16'd5, 16'd3, 1'b0);
		queue_proc(16'd7, 16'd0, 1'b0);
		queue_proc(16'd0, 16'd4, 1'b1);
		// cpu idle before the first arrival and between arrivals
		queue_proc(16'd100, 16'd2, 1'b0);
		queue_proc(16'd40, 16'd1, 1'b1);
		// full table, then a closing item that is dropped for capacity
		for (int k = 0; k < CAPACITY; k++)
			queue_proc(ARR_W'((k % 5) * 3), BUR_W'((k * 7) % 9 + 1), 1'b0);
		queue_proc(16'd0, 16'd9, 1'b1);

		// random sets, mostly small, some full, some past capacity, a few empty
		while (procs_queued < ITEM_TARGET) begin
			size_kind = $urandom_range(0, 99);
			if (size_kind < 65)
				n = $urandom_range(1, 6);
			else if (size_kind < 85)
				n = $urandom_range(7, CAPACITY);
			else if (size_kind < 94)
				n = $urandom_range(CAPACITY + 1, CAPACITY + 4);
			else
				n = 0;
			span = $urandom_range(0, 3);
			bur_kind = $urandom_range(0, 2);
			for (int k = 0; k < n; k++) begin
				b = pick_burst(bur_kind);
				if ($urandom_range(0, 19) == 0)
					b = '0;
				queue_proc(pick_arrival(span), b, k == n - 1);
			end
			if (n == 0)
				queue_proc(ARR_W'($urandom_range(0, 65535)), 16'd0, 1'b1);
		end

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// all items sent and every predicted report seen
		while (procs_to_send.size() != 0 || in_valid || reports_due.size() != 0)
			@(posedge clk);
		// a short tail to catch stray results
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
